/* hdl/assert_macros.svh */
// Assertion macros used by days_between_dates_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dbd_pkg.sv */
// Types, widths and tables for the day distance block.
`default_nettype none

package dbd_pkg;

  localparam int YearW  = 12;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int OrdW   = 21;   // ordinal of year 4095 still fits
  localparam int DistW  = 21;
  localparam int QuotW  = 6;    // year / 100 for a 12-bit year
  localparam int DbmW   = 9;

  // year / 100 == (year * 5243) >> 19 for every 12-bit year
  localparam int RecipW     = 13;
  localparam int ProdW      = YearW + RecipW;
  localparam int RecipShift = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;

  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [OrdW-1:0]   ord_t;
  typedef logic [DistW-1:0]  dist_t;
  typedef logic [DbmW-1:0]   dbm_t;
  typedef logic [QuotW-1:0]  quot_t;

  // Days before month m in a common year; codes above December count all twelve
  function automatic dbm_t days_before_month(input month_t m);
    dbm_t r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/dbd_in_if.sv */
// Request channel carrying a pair of dates.
`default_nettype none

interface dbd_in_if;
  logic             valid;
  logic             ready;
  dbd_pkg::year_t   first_year;
  dbd_pkg::month_t  first_month;
  dbd_pkg::day_t    first_day;
  dbd_pkg::year_t   second_year;
  dbd_pkg::month_t  second_month;
  dbd_pkg::day_t    second_day;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    input  ready
  );
  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/dbd_out_if.sv */
// Result channel carrying the day distance and order flag.
`default_nettype none

interface dbd_out_if;
  logic            valid;
  logic            ready;
  dbd_pkg::dist_t  day_distance;
  logic            order_swapped;

  modport source (output valid, day_distance, order_swapped, input ready);
  modport sink   (input  valid, day_distance, order_swapped, output ready);
endinterface

`default_nettype wire

/* hdl/days_between_dates_core.sv */
// Path: stage 1 clamps and compares, stages 2..4 form the ordinals, stage 5 registers the difference.
// Throughput: one date pair per cycle unless the output stalls; each stage loads when empty or draining.
// The critical stage is the year-day sum (constant multiply by 365 plus adds).
// Reset: synchronous, clears all stage valid bits; payload registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module days_between_dates_core #(
  parameter int MAX_YEAR = 3000
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dbd_in_if.sink      dates,
  dbd_out_if.source   result
);

  localparam dbd_pkg::year_t YearCap =
    (MAX_YEAR > (2 ** dbd_pkg::YearW) - 1) ? '1 : dbd_pkg::YearW'(MAX_YEAR);

  // Stage valid bits and load enables (stage 1 .. stage 5)
  logic [4:0] v;
  logic [4:0] en;

  assign en[4] = !v[4] || result.ready;
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];

  assign dates.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= dates.valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  // Stage 1: clamp years, lexicographic order compare
  dbd_pkg::year_t  ya_c, yb_c;
  logic            swap_next;

  always_comb begin
    ya_c = dates.first_year;
    if (dates.first_year == '0) ya_c = dbd_pkg::YearW'(1);
    else if (32'(dates.first_year) > MAX_YEAR) ya_c = YearCap;
    yb_c = dates.second_year;
    if (dates.second_year == '0) yb_c = dbd_pkg::YearW'(1);
    else if (32'(dates.second_year) > MAX_YEAR) yb_c = YearCap;

    if (ya_c != yb_c)
      swap_next = ya_c > yb_c;
    else if (dates.first_month != dates.second_month)
      swap_next = dates.first_month > dates.second_month;
    else
      swap_next = dates.first_day > dates.second_day;
  end

  dbd_pkg::year_t  ya1, yb1;
  dbd_pkg::month_t ma1, mb1;
  dbd_pkg::day_t   da1, db1;
  logic [3:0]      swp;   // order flag through stages 1..4

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ya1    <= ya_c;
      yb1    <= yb_c;
      ma1    <= dates.first_month;
      mb1    <= dates.second_month;
      da1    <= dates.first_day;
      db1    <= dates.second_day;
      swp[0] <= swap_next;
    end
    if (en[1]) swp[1] <= swp[0];
    if (en[2]) swp[2] <= swp[1];
    if (en[3]) swp[3] <= swp[2];
  end

  // Stages 2..4: day ordinal of each date
  dbd_pkg::ord_t ord_a, ord_b;

  dbd_ordinal u_ord_a (
    .clk     (clk),
    .en      (en[3:1]),
    .year    (ya1),
    .month   (ma1),
    .day     (da1),
    .ordinal (ord_a)
  );

  dbd_ordinal u_ord_b (
    .clk     (clk),
    .en      (en[3:1]),
    .year    (yb1),
    .month   (mb1),
    .day     (db1),
    .ordinal (ord_b)
  );

  // Stage 5: absolute difference into the output register
  dbd_pkg::dist_t dist_next;
  assign dist_next = (ord_a > ord_b) ? dbd_pkg::DistW'(ord_a - ord_b)
                                     : dbd_pkg::DistW'(ord_b - ord_a);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      result.day_distance  <= dist_next;
      result.order_swapped <= swp[3];
    end
  end

  assign result.valid = v[4];

  // Checks
  `ASSERT_NEXT(a_accept_loads, clk, rst, dates.valid && dates.ready, v[0], "accepted request not in stage 1")
  `ASSERT_SAME(a_year_clamped, clk, rst, v[0], (ya1 != '0) && (32'(ya1) <= MAX_YEAR) && (yb1 != '0) && (32'(yb1) <= MAX_YEAR), "stage 1 year outside clamp range")
  `ASSERT_SAME(a_swap_years, clk, rst, v[0] && swp[0], ya1 >= yb1, "order flag set with earlier first year")

endmodule

`default_nettype wire

/* hdl/dbd_ordinal.sv */
// Three-stage day ordinal of one clamped date.
`default_nettype none

module dbd_ordinal (
  input  wire logic            clk,
  input  wire logic [2:0]      en,      // stage load enables, bit 0 is the first stage
  input  wire dbd_pkg::year_t  year,    // already clamped to 1..max
  input  wire dbd_pkg::month_t month,
  input  wire dbd_pkg::day_t   day,
  output dbd_pkg::ord_t        ordinal
);

  // Stage A: year / 100 by reciprocal multiply
  dbd_pkg::year_t  ya;
  dbd_pkg::month_t ma;
  dbd_pkg::day_t   da;
  dbd_pkg::quot_t  qa;
  logic [dbd_pkg::ProdW-1:0] prod;

  assign prod = dbd_pkg::ProdW'(year) * dbd_pkg::ProdW'(dbd_pkg::Recip100);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ya <= year;
      ma <= month;
      da <= day;
      qa <= prod[dbd_pkg::RecipShift +: dbd_pkg::QuotW];
    end
  end

  // Stage B: leap flag and days of all full preceding years
  dbd_pkg::year_t  rem;
  dbd_pkg::year_t  p;
  dbd_pkg::quot_t  c100;
  logic            cent;
  logic            leap_next;
  dbd_pkg::ord_t   base_next;

  dbd_pkg::month_t mb;
  dbd_pkg::day_t   db;
  dbd_pkg::ord_t   base;
  logic            leap;

  always_comb begin
    rem       = ya - dbd_pkg::YearW'(qa) * dbd_pkg::YearW'(100);
    cent      = (rem == '0);
    leap_next = cent ? (qa[1:0] == 2'b00) : (ya[1:0] == 2'b00);
    p         = ya - dbd_pkg::YearW'(1);
    c100      = qa - dbd_pkg::QuotW'(cent);   // (year-1) / 100
    base_next = dbd_pkg::OrdW'(p) * dbd_pkg::OrdW'(365)
              + dbd_pkg::OrdW'(p >> 2)
              - dbd_pkg::OrdW'(c100)
              + dbd_pkg::OrdW'(c100 >> 2);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mb   <= ma;
      db   <= da;
      base <= base_next;
      leap <= leap_next;
    end
  end

  // Stage C: months before this one, leap day, day of month
  logic leap_add;
  assign leap_add = leap && (mb > dbd_pkg::MonthFeb);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ordinal <= base
               + dbd_pkg::OrdW'(dbd_pkg::days_before_month(mb))
               + dbd_pkg::OrdW'(leap_add)
               + dbd_pkg::OrdW'(db);
    end
  end

endmodule

`default_nettype wire
